// File: rtl/core/tmmet_pkg.sv
`timescale 1ns / 1ps
// Package for the three-channel min/max/mean and energy tracker.
// Holds field widths, constants, the controller state type and the
// command and status structs shared by the controller and datapath.
package tmmet_pkg;

    localparam int FIELD_W    = 32;
    localparam int CNT_W      = 32;
    localparam int ENERGY_W   = 43;
    localparam int NUM_CH     = 3;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 336;
    localparam int OUT_PAD_W  = OUT_DATA_W - 9 * FIELD_W - ENERGY_W;

    localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] ENERGY_DIVISOR = 32'd3600000;

    // The energy divisor is 28125 * 2^7. A sample shifted right by ENERGY_SHIFT is
    // divided by 28125 through multiplication with ceil(2^40 / 28125), exact for
    // every 25-bit operand; the quotient then sits in the top EQ_W product bits.
    localparam int ENERGY_SHIFT = 7;
    localparam int RECIP_W      = 26;
    localparam int EQ_W         = 11;
    localparam int EREM_W       = 22;

    localparam logic [RECIP_W-1:0] ENERGY_RECIP = 26'd39093747;
    localparam logic [EREM_W-1:0]  ENERGY_DIV_R = EREM_W'(ENERGY_DIVISOR);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_START,
        S_DIV_WAIT,
        S_ENERGY,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_VOLT,
        SEL_CURR,
        SEL_POW,
        SEL_ENERGY
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     update;
        logic     div_start;
        logic     div_write;
        logic     load_out;
        t_div_sel div_sel;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic counting;
        logic div_busy;
        logic div_done;
    } t_status;

endpackage

// File: rtl/core/tmmet_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, for quotients that fit
// SAMPLE_BITS. Depends on tmmet_pkg for the divisor width.
module tmmet_div #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [SAMPLE_BITS+tmmet_pkg::CNT_W-1:0]       i_dividend,
    input  logic [tmmet_pkg::CNT_W-1:0]                   i_divisor,
    output logic                                          o_busy,
    output logic                                          o_done,
    output logic [SAMPLE_BITS+tmmet_pkg::CNT_W-1:0]       o_quotient
);
    import tmmet_pkg::*;

    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int STEPS_W = $clog2(SAMPLE_BITS + 1);

    logic               r_busy;
    logic               r_done;
    logic [STEPS_W-1:0] r_steps;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_div;
    logic [SUM_W-1:0]   r_acc;

    logic [CNT_W:0]     w_trial;
    logic [CNT_W:0]     w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_acc[SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEPS_W'(SAMPLE_BITS);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == STEPS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient is known to fit SAMPLE_BITS, so the upper word of the
    // dividend is already a valid partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= i_dividend[SUM_W-1 -: CNT_W];
            r_acc <= {i_dividend[SAMPLE_BITS-1:0], {CNT_W{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_acc <= {r_acc[SUM_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_acc;

endmodule

// File: rtl/core/tmmet_datapath.sv
`timescale 1ns / 1ps
// Datapath: input latch, statistics registers, divider operand selection,
// the energy update and the output register. Depends on tmmet_pkg and tmmet_div.
module tmmet_datapath #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [tmmet_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic                                i_in_clear,
    input  tmmet_pkg::t_cmd                     i_cmd,
    output tmmet_pkg::t_status                  o_status,
    output logic [tmmet_pkg::OUT_DATA_W-1:0]    o_out_data
);
    import tmmet_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int X_W    = FIELD_W - ENERGY_SHIFT;
    localparam int PROD_W = X_W + RECIP_W;

    logic                   r_in_clear;
    logic [SAMPLE_BITS-1:0] r_in_v   [NUM_CH];
    logic [SAMPLE_BITS-1:0] r_max    [NUM_CH];
    logic [SAMPLE_BITS-1:0] r_min    [NUM_CH];
    logic [SUM_W-1:0]       r_sum    [NUM_CH];
    logic [SAMPLE_BITS-1:0] r_mean   [NUM_CH];
    logic [CNT_W-1:0]       r_count;
    logic [ENERGY_W-1:0]    r_energy;
    logic [EREM_W-1:0]      r_erem;
    logic [PROD_W-1:0]      r_e_prod;
    logic [FIELD_W-1:0]     r_e_qd;
    logic [EREM_W-1:0]      r_e_part;
    logic [EREM_W:0]        r_e_tot;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic                   w_counting;
    logic [SUM_W-1:0]       w_dividend;
    logic                   w_div_busy;
    logic                   w_div_done;
    logic [SUM_W-1:0]       w_quotient;
    logic [FIELD_W-1:0]     w_e_smp;
    logic [X_W-1:0]         w_e_x;
    logic [EQ_W-1:0]        w_e_quot;
    logic [FIELD_W-1:0]     w_e_rdiff;
    logic                   w_e_wrap;
    logic [EREM_W:0]        w_e_wdiff;
    logic [OUT_DATA_W-1:0]  w_out_data;

    assign w_counting = r_count != COUNT_MAX;

    always_comb begin
        case (i_cmd.div_sel)
            SEL_VOLT:   w_dividend = r_sum[0];
            SEL_CURR:   w_dividend = r_sum[1];
            SEL_POW:    w_dividend = r_sum[2];
            default:    w_dividend = r_sum[2];
        endcase
    end

    tmmet_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // The energy total is held as quotient and remainder of the power sum. The
    // latched power sample is split into quotient and remainder over four
    // registered steps that settle long before the means are done.
    assign w_e_smp   = FIELD_W'(r_in_v[2]);
    assign w_e_x     = w_e_smp[FIELD_W-1:ENERGY_SHIFT];
    assign w_e_quot  = r_e_prod[PROD_W-1 -: EQ_W];
    assign w_e_rdiff = w_e_smp - r_e_qd;
    assign w_e_wrap  = r_e_tot >= {1'b0, ENERGY_DIV_R};
    assign w_e_wdiff = r_e_tot - {1'b0, ENERGY_DIV_R};

    always_ff @(posedge i_clk) begin
        r_e_prod <= PROD_W'(w_e_x) * PROD_W'(ENERGY_RECIP);
        r_e_qd   <= FIELD_W'(w_e_quot) * ENERGY_DIVISOR;
        r_e_part <= w_e_rdiff[EREM_W-1:0];
        r_e_tot  <= {1'b0, r_erem} + {1'b0, r_e_part};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_clear <= i_in_clear;
            for (int c = 0; c < NUM_CH; c++) begin
                r_in_v[c] <= i_in_data[c*FIELD_W +: SAMPLE_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_max[c]  <= '0;
                r_min[c]  <= '1;
                r_sum[c]  <= '0;
                r_mean[c] <= '0;
            end
            r_count  <= '0;
            r_energy <= '0;
            r_erem   <= '0;
        end else if (i_cmd.update) begin
            if (r_in_clear) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_max[c]  <= '0;
                    r_min[c]  <= '1;
                    r_sum[c]  <= '0;
                    r_mean[c] <= '0;
                end
                r_count  <= '0;
                r_energy <= '0;
                r_erem   <= '0;
            end else begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (r_in_v[c] > r_max[c]) begin
                        r_max[c] <= r_in_v[c];
                    end
                    if (r_in_v[c] < r_min[c]) begin
                        r_min[c] <= r_in_v[c];
                    end
                    if (w_counting) begin
                        r_sum[c] <= r_sum[c] + SUM_W'(r_in_v[c]);
                    end
                end
                if (w_counting) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end else if (i_cmd.div_write) begin
            case (i_cmd.div_sel)
                SEL_VOLT:   r_mean[0] <= w_quotient[SAMPLE_BITS-1:0];
                SEL_CURR:   r_mean[1] <= w_quotient[SAMPLE_BITS-1:0];
                SEL_POW:    r_mean[2] <= w_quotient[SAMPLE_BITS-1:0];
                SEL_ENERGY: begin
                    r_energy <= r_energy + ENERGY_W'(w_e_quot) + ENERGY_W'(w_e_wrap);
                    r_erem   <= w_e_wrap ? w_e_wdiff[EREM_W-1:0] : r_e_tot[EREM_W-1:0];
                end
                default:    r_energy  <= r_energy;
            endcase
        end
    end

    always_comb begin
        w_out_data = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            w_out_data[(3*c)*FIELD_W   +: FIELD_W] = FIELD_W'(r_min[c]);
            w_out_data[(3*c+1)*FIELD_W +: FIELD_W] = FIELD_W'(r_max[c]);
            w_out_data[(3*c+2)*FIELD_W +: FIELD_W] = FIELD_W'(r_mean[c]);
        end
        w_out_data[9*FIELD_W +: ENERGY_W] = r_energy;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= w_out_data;
        end
    end

    assign o_status.is_clear = r_in_clear;
    assign o_status.counting = w_counting;
    assign o_status.div_busy = w_div_busy;
    assign o_status.div_done = w_div_done;
    assign o_out_data        = r_out_data;

endmodule

// File: rtl/core/tmmet_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences capture, update, three divisions,
// the energy update and the output load. Depends on tmmet_pkg.
module tmmet_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tmmet_pkg::t_status i_status,
    output tmmet_pkg::t_cmd    o_cmd
);
    import tmmet_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_div_sel r_sel;
    t_div_sel n_sel;
    logic     r_out_valid;
    logic     n_out_valid;
    t_cmd     w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_VOLT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sel          = r_sel;
        w_cmd          = '0;
        w_cmd.div_sel  = r_sel;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                w_cmd.update = 1'b1;
                if (!i_status.is_clear && i_status.counting) begin
                    n_sel   = SEL_VOLT;
                    n_state = S_DIV_START;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV_START: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    w_cmd.div_write = 1'b1;
                    n_state         = S_DIV_START;
                    case (r_sel)
                        SEL_VOLT:   n_sel = SEL_CURR;
                        SEL_CURR:   n_sel = SEL_POW;
                        SEL_POW: begin
                            n_sel   = SEL_ENERGY;
                            n_state = S_ENERGY;
                        end
                        SEL_ENERGY: n_state = S_OUT;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_ENERGY: begin
                w_cmd.div_write = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !i_status.div_busy)
        else $error("Division started while the divider is busy.");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DIV_WAIT))
        else $error("Divider finished outside the wait state.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("Output register loaded over a pending result.");

    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("Output valid rose without an output load.");
`endif

endmodule

// File: rtl/core/triple_min_max_mean_energy_tracker_unit.sv
`timescale 1ns / 1ps
// Top level of the three-channel min/max/mean and energy tracker.
// Depends on tmmet_pkg, tmmet_ctrl, tmmet_datapath and tmmet_div.
//
// Channel   Dir  Bus        Contents
// s_axis    in   tdata 96   voltage, current, power samples; tuser = clear request
// m_axis    out  tdata 336  min/max/mean per channel, then energy total
//
// A sample's result is loaded after capture, update, three runs of the shared
// one-bit-per-cycle divider for the means, and the energy update.
// A clear request, or a sample once the count is saturated, is loaded after capture and update.
// The input is ready again in the cycle after the load.
// The reset is synchronous and active low and returns all statistics to their
// cleared values. A stalled result waits in the output register while the next
// item is accepted and processed.
module triple_min_max_mean_energy_tracker_unit #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // voltage_sample [31:0], current_sample [63:32], power_sample [95:64]
    input  logic [tmmet_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // voltage_min, voltage_max, voltage_mean, current_min, current_max,
    // current_mean, power_min, power_max, power_mean (32 bits each from bit 0),
    // energy_total [330:288], zero pad [335:331]
    output logic [tmmet_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import tmmet_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tmmet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tmmet_datapath #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (s_axis_tdata),
        .i_in_clear (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (m_axis_tdata)
    );

endmodule
